### rtl/eased_interpolation_slot_engine_macros.svh
// assertion helpers shared by the engine rtl
`ifndef EASED_INTERPOLATION_SLOT_ENGINE_MACROS_SVH
`define EASED_INTERPOLATION_SLOT_ENGINE_MACROS_SVH

// same-cycle implication, masked while reset is held
`define EIS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, also checked through reset
`define EIS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/eis_pkg.sv
// ----------------------------------------------------------------------------
// eis_pkg
// Shared widths, command and easing codes and types of the interpolation
// slot engine.
// ----------------------------------------------------------------------------
package eis_pkg;

    localparam int SLOTS_DEFAULT = 16;
    localparam int MAX_RESULTS   = 16;

    localparam int VAL_W    = 32;
    localparam int DUR_W    = 24;
    localparam int DT_W     = 16;
    localparam int HANDLE_W = 32;
    localparam int GEN_W    = 16;
    localparam int MODE_W   = 3;
    localparam int FRAC_W   = 16;
    localparam int Q_W      = FRAC_W + 1;   // progress 0..1.0 inclusive
    localparam int OP_W     = 20;           // easing operand width
    localparam int MA_W     = VAL_W + 1;    // multiplier a side
    localparam int PROD_W   = MA_W + OP_W;

    localparam logic [Q_W-1:0] Q_ONE = Q_W'(1) << FRAC_W;

    localparam logic [1:0] CMD_START  = 2'd0;
    localparam logic [1:0] CMD_CANCEL = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;
    localparam logic [1:0] CMD_TICK   = 2'd3;

    localparam logic [MODE_W-1:0] EASE_LINEAR  = 3'd0;
    localparam logic [MODE_W-1:0] EASE_IN      = 3'd1;
    localparam logic [MODE_W-1:0] EASE_OUT     = 3'd2;
    localparam logic [MODE_W-1:0] EASE_IN_OUT  = 3'd3;
    localparam logic [MODE_W-1:0] EASE_SMOOTH  = 3'd4;
    localparam logic [MODE_W-1:0] EASE_SMOOTHER = 3'd5;

    typedef struct packed {
        logic busy;
        logic done;
    } eis_div_status_t;

    typedef struct packed {
        logic [VAL_W-1:0]  start_val;
        logic [VAL_W-1:0]  end_val;
        logic [DUR_W-1:0]  dur;
        logic [DUR_W-1:0]  elapsed;
        logic [MODE_W-1:0] ease;
    } eis_slot_t;

endpackage

### rtl/eis_div.sv
// ----------------------------------------------------------------------------
// eis_div
// Restoring divider for progress: floor(num * 2^16 / den) with num <= den,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module eis_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [eis_pkg::DUR_W-1:0]     num,
    input  logic [eis_pkg::DUR_W-1:0]     den,
    output logic [eis_pkg::Q_W-1:0]       quotient,
    output eis_pkg::eis_div_status_t      status
);

    localparam int R_W   = eis_pkg::DUR_W + 1;
    localparam int CNT_W = $clog2(eis_pkg::FRAC_W + 1);

    logic             busy_reg, done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [R_W-1:0]   rem_reg;
    logic [R_W-1:0]   rem_dbl;
    logic             q_bit;
    logic [eis_pkg::Q_W-1:0] quot_reg;

    assign rem_dbl = {rem_reg[R_W-2:0], 1'b0};
    assign q_bit   = rem_dbl >= R_W'(den);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                if (num >= den) begin
                    done_reg <= 1'b1;
                end else begin
                    busy_reg <= 1'b1;
                end
            end else if (busy_reg && cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= R_W'(num);
            cnt_reg  <= CNT_W'(eis_pkg::FRAC_W);
            // full progress when elapsed has reached the duration
            quot_reg <= (num >= den) ? eis_pkg::Q_ONE : '0;
        end else if (busy_reg) begin
            rem_reg  <= q_bit ? rem_dbl - R_W'(den) : rem_dbl;
            quot_reg <= {quot_reg[eis_pkg::Q_W-2:0], q_bit};
            cnt_reg  <= cnt_reg - CNT_W'(1);
        end
    end

    assign quotient    = quot_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

### rtl/eased_interpolation_slot_engine.sv
// ----------------------------------------------------------------------------
// eased_interpolation_slot_engine
// Table of tween slots with easing curves, driven by start, cancel, query
// and tick commands.
// ----------------------------------------------------------------------------
// Start, cancel and query each give one result. A tick walks the table one
// slot at a time: a free slot is passed over, an active slot is read, its
// progress is found by the 16-step progress divider (which returns full
// progress at once on the tick where the slot reaches its end), then eased
// and blended on the shared multiplier (zero to four easing products plus
// the final blend), plus any wait for the result to be taken. Slot payload
// lives in one memory with a registered read; busy flags and generations
// are flip-flops.
module eased_interpolation_slot_engine #(
    parameter int SLOTS = eis_pkg::SLOTS_DEFAULT
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [1:0]                             s_cmd,
    input  logic signed [eis_pkg::VAL_W-1:0]       s_start_value,
    input  logic signed [eis_pkg::VAL_W-1:0]       s_end_value,
    input  logic [eis_pkg::DUR_W-1:0]              s_duration,
    input  logic [eis_pkg::MODE_W-1:0]             s_ease_mode,
    input  logic [eis_pkg::HANDLE_W-1:0]           s_handle,
    input  logic [eis_pkg::DT_W-1:0]               s_time_step,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [1:0]                             m_kind,
    output logic [eis_pkg::HANDLE_W-1:0]           m_slot_handle,
    output logic signed [eis_pkg::VAL_W-1:0]       m_value,
    output logic                                   m_finished,
    output logic                                   m_found,
    output logic                                   m_last
);

    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int N_W    = $clog2(eis_pkg::MAX_RESULTS + 1);
    localparam int VAL_W  = eis_pkg::VAL_W;
    localparam int GEN_W  = eis_pkg::GEN_W;
    localparam int OP_W   = eis_pkg::OP_W;
    localparam int Q_W    = eis_pkg::Q_W;
    localparam int MA_W   = eis_pkg::MA_W;
    localparam int PROD_W = eis_pkg::PROD_W;
    localparam int FRAC_W = eis_pkg::FRAC_W;
    localparam int DUR_W  = eis_pkg::DUR_W;

    localparam logic [OP_W-1:0] ONE = OP_W'(eis_pkg::Q_ONE);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_TRD   = 4'd1;
    localparam logic [3:0] ST_TLD   = 4'd2;
    localparam logic [3:0] ST_TDIV  = 4'd3;
    localparam logic [3:0] ST_EMUL  = 4'd4;
    localparam logic [3:0] ST_ERES  = 4'd5;
    localparam logic [3:0] ST_EFIN  = 4'd6;
    localparam logic [3:0] ST_LMUL  = 4'd7;
    localparam logic [3:0] ST_LRES  = 4'd8;
    localparam logic [3:0] ST_TOUT  = 4'd9;
    localparam logic [3:0] ST_EMPTY = 4'd10;

    function automatic logic [1:0] last_step(input logic [eis_pkg::MODE_W-1:0] mode);
        case (mode)
            eis_pkg::EASE_SMOOTH:   last_step = 2'd1;
            eis_pkg::EASE_SMOOTHER: last_step = 2'd3;
            default:                last_step = 2'd0;
        endcase
    endfunction

    function automatic logic has_steps(input logic [eis_pkg::MODE_W-1:0] mode);
        case (mode)
            eis_pkg::EASE_IN, eis_pkg::EASE_OUT, eis_pkg::EASE_IN_OUT,
            eis_pkg::EASE_SMOOTH, eis_pkg::EASE_SMOOTHER: has_steps = 1'b1;
            default: has_steps = 1'b0;
        endcase
    endfunction

    // state and control
    logic [3:0]               state_reg, state_next;
    logic [IDX_W-1:0]         i_reg, i_next;
    logic [N_W-1:0]           n_reg, n_next;
    logic [eis_pkg::DT_W-1:0] dt_reg;
    logic                     used_reg [SLOTS];
    logic [GEN_W-1:0]         gen_reg  [SLOTS];

    // slot memory
    eis_pkg::eis_slot_t slot_mem [SLOTS];
    eis_pkg::eis_slot_t rd_data, slot_reg, wr_data;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;

    // datapath
    logic [Q_W-1:0]      p_reg;
    logic                fin_reg;
    logic [1:0]          step_reg;
    logic [OP_W-1:0]     t_reg, a_reg;
    logic [Q_W-1:0]      e_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [VAL_W-1:0]    val_reg;
    logic [MA_W-1:0]     mul_a;
    logic [OP_W-1:0]     mul_b;
    logic [PROD_W-1:0]   rnd;
    logic [OP_W-1:0]     op_a, op_b;
    logic [OP_W:0]       e_raw;
    logic [OP_W:0]       t_dbl;
    logic                p_half;

    // divider
    logic                      div_start;
    logic                      div_start_q;
    logic [DUR_W-1:0]          el_new;
    logic [DUR_W:0]            el_sum;
    logic [DUR_W-1:0]          el_hold;
    logic [Q_W-1:0]            div_q;
    eis_pkg::eis_div_status_t  div_st;

    // blend
    logic [MA_W-1:0] diff, mag;
    logic            neg;
    logic [MA_W-1:0] d_mag, v_full;

    // table updates
    logic             set_en, free_en;
    logic [IDX_W-1:0] upd_idx;

    // command decode
    logic             s_fire;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic             h_in_range, h_hit;
    logic [IDX_W-1:0] h_idx;
    logic             later_any;
    logic             out_free;

    // output register
    logic                      m_valid_reg;
    logic                      out_load;
    logic [1:0]                out_kind;
    logic [eis_pkg::HANDLE_W-1:0] out_handle;
    logic [VAL_W-1:0]          out_value;
    logic                      out_fin, out_found, out_last;
    logic [1:0]                kind_reg;
    logic [eis_pkg::HANDLE_W-1:0] handle_reg;
    logic [VAL_W-1:0]          value_reg;
    logic                      finished_reg, found_reg, last_reg;

    eis_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .num      (el_new),
        .den      (slot_reg.dur),
        .quotient (div_q),
        .status   (div_st)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign s_fire   = s_valid && s_ready;

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int j = SLOTS - 1; j >= 0; j--) begin
            if (!used_reg[j]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(j);
            end
        end
    end

    assign h_in_range = (s_handle[15:0] != 16'd0) && (17'(s_handle[15:0]) <= 17'(SLOTS));
    assign h_idx      = IDX_W'(s_handle[15:0] - 16'd1);
    assign h_hit      = h_in_range && used_reg[h_idx] &&
                        (gen_reg[h_idx] == s_handle[31:16]);

    // any active slot above the current one
    always_comb begin
        later_any = 1'b0;
        for (int j = 0; j < SLOTS; j++) begin
            if (used_reg[j] && (IDX_W'(j) > i_reg)) begin
                later_any = 1'b1;
            end
        end
    end

    assign el_sum = (DUR_W + 1)'(rd_data.elapsed) + (DUR_W + 1)'(dt_reg);
    assign el_new = (el_sum > (DUR_W + 1)'(slot_reg.dur)) ? slot_reg.dur
                                                          : el_sum[DUR_W-1:0];

    // easing operands per step
    assign p_half = p_reg < (Q_W'(1) << (FRAC_W - 1));
    always_comb begin
        op_a = OP_W'(p_reg);
        op_b = OP_W'(p_reg);
        case (step_reg)
            2'd0: begin
                case (slot_reg.ease)
                    eis_pkg::EASE_OUT: op_b = (ONE << 1) - OP_W'(p_reg);
                    eis_pkg::EASE_IN_OUT: begin
                        if (!p_half) begin
                            op_a = ONE - OP_W'(p_reg);
                            op_b = ONE - OP_W'(p_reg);
                        end
                    end
                    default: ;
                endcase
            end
            2'd1: begin
                op_a = t_reg;
                if (slot_reg.ease == eis_pkg::EASE_SMOOTH) begin
                    op_b = OP_W'(3) * ONE - (OP_W'(p_reg) << 1);
                end
            end
            2'd2: op_b = OP_W'(15) * ONE - OP_W'(6) * OP_W'(p_reg);
            default: begin
                op_a = t_reg;
                op_b = OP_W'(10) * ONE - a_reg;
            end
        endcase
    end

    // blend terms
    assign diff = {slot_reg.end_val[VAL_W-1], slot_reg.end_val}
                - {slot_reg.start_val[VAL_W-1], slot_reg.start_val};
    assign neg  = diff[MA_W-1];
    assign mag  = neg ? -diff : diff;

    assign mul_a = (state_reg == ST_LMUL) ? mag : MA_W'(op_a);
    assign mul_b = (state_reg == ST_LMUL) ? OP_W'(e_reg) : op_b;
    assign rnd   = prod_reg + PROD_W'(32768);
    assign d_mag = rnd[FRAC_W +: MA_W];
    assign v_full = neg ? {slot_reg.start_val[VAL_W-1], slot_reg.start_val} - d_mag
                        : {slot_reg.start_val[VAL_W-1], slot_reg.start_val} + d_mag;

    // eased value before the clamp
    assign t_dbl = {t_reg, 1'b0};
    always_comb begin
        case (slot_reg.ease)
            eis_pkg::EASE_IN, eis_pkg::EASE_OUT, eis_pkg::EASE_SMOOTH,
            eis_pkg::EASE_SMOOTHER: e_raw = (OP_W + 1)'(t_reg);
            eis_pkg::EASE_IN_OUT: begin
                if (p_half) begin
                    e_raw = t_dbl;
                end else if (t_dbl > (OP_W + 1)'(ONE)) begin
                    e_raw = '0;
                end else begin
                    e_raw = (OP_W + 1)'(ONE) - t_dbl;
                end
            end
            default: e_raw = (OP_W + 1)'(p_reg);
        endcase
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        i_next     = i_reg;
        n_next     = n_reg;
        div_start  = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = i_reg;
        wr_data    = slot_reg;
        set_en     = 1'b0;
        free_en    = 1'b0;
        upd_idx    = i_reg;
        out_load   = 1'b0;
        out_kind   = eis_pkg::CMD_TICK;
        out_handle = '0;
        out_value  = '0;
        out_fin    = 1'b0;
        out_found  = 1'b0;
        out_last   = 1'b1;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    case (s_cmd)
                        eis_pkg::CMD_START: begin
                            out_load = 1'b1;
                            out_kind = eis_pkg::CMD_START;
                            if (free_found) begin
                                set_en            = 1'b1;
                                upd_idx           = free_idx;
                                wr_en             = 1'b1;
                                wr_addr           = free_idx;
                                wr_data.start_val = s_start_value;
                                wr_data.end_val   = s_end_value;
                                wr_data.dur       = (s_duration == '0) ? DUR_W'(1)
                                                                       : s_duration;
                                wr_data.elapsed   = '0;
                                wr_data.ease      = s_ease_mode;
                                out_handle = {gen_reg[free_idx], 16'(free_idx) + 16'd1};
                                out_value  = s_start_value;
                                out_found  = 1'b1;
                            end
                        end
                        eis_pkg::CMD_CANCEL, eis_pkg::CMD_QUERY: begin
                            out_load   = 1'b1;
                            out_kind   = s_cmd;
                            out_handle = s_handle;
                            out_found  = h_hit;
                            if (h_hit && s_cmd == eis_pkg::CMD_CANCEL) begin
                                free_en = 1'b1;
                                upd_idx = h_idx;
                            end
                        end
                        default: begin
                            i_next     = '0;
                            n_next     = '0;
                            state_next = ST_TRD;
                        end
                    endcase
                end
            end
            ST_TRD: begin
                if (used_reg[i_reg]) begin
                    state_next = ST_TLD;
                end else if (i_reg == IDX_W'(SLOTS - 1)) begin
                    state_next = (n_reg == '0) ? ST_EMPTY : ST_IDLE;
                end else begin
                    i_next = i_reg + IDX_W'(1);
                end
            end
            ST_TLD: begin
                state_next = ST_TDIV;
            end
            ST_TDIV: begin
                // elapsed write-back and divider start happen in the cycle after the load state
                if (div_st.done) begin
                    state_next = has_steps(slot_reg.ease) ? ST_EMUL : ST_EFIN;
                end
            end
            ST_EMUL: state_next = ST_ERES;
            ST_ERES: state_next = (step_reg == last_step(slot_reg.ease)) ? ST_EFIN : ST_EMUL;
            ST_EFIN: state_next = ST_LMUL;
            ST_LMUL: state_next = ST_LRES;
            ST_LRES: state_next = ST_TOUT;
            ST_TOUT: begin
                if (n_reg >= N_W'(eis_pkg::MAX_RESULTS) || out_free) begin
                    if (n_reg < N_W'(eis_pkg::MAX_RESULTS)) begin
                        out_load   = 1'b1;
                        out_handle = {gen_reg[i_reg], 16'(i_reg) + 16'd1};
                        out_value  = val_reg;
                        out_fin    = fin_reg;
                        out_found  = 1'b1;
                        out_last   = (n_reg == N_W'(eis_pkg::MAX_RESULTS - 1)) || !later_any;
                        n_next     = n_reg + N_W'(1);
                    end
                    free_en = fin_reg;
                    if (i_reg == IDX_W'(SLOTS - 1)) begin
                        state_next = ST_IDLE;
                    end else begin
                        i_next     = i_reg + IDX_W'(1);
                        state_next = ST_TRD;
                    end
                end
            end
            ST_EMPTY: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (state_reg == ST_TDIV && div_start_q && !div_st.busy) begin
            div_start = 1'b1;
        end
    end

    // first cycle of the divide state launches the divider and writes elapsed back
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_start_q <= 1'b0;
        end else begin
            div_start_q <= (state_reg == ST_TLD);
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_TLD) begin
            slot_reg <= rd_data;
        end else if (wr_en && state_reg == ST_IDLE) begin
            slot_reg <= slot_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            i_reg       <= '0;
            n_reg       <= '0;
            m_valid_reg <= 1'b0;
            for (int j = 0; j < SLOTS; j++) begin
                used_reg[j] <= 1'b0;
                gen_reg[j]  <= '0;
            end
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            n_reg     <= n_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (set_en) begin
                used_reg[upd_idx] <= 1'b1;
            end
            if (free_en) begin
                used_reg[upd_idx] <= 1'b0;
                gen_reg[upd_idx]  <= gen_reg[upd_idx] + GEN_W'(1);
            end
        end
    end

    // slot memory, one write and one registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_mem[wr_addr] <= wr_data;
        end else if (div_start) begin
            slot_mem[i_reg] <= '{start_val: slot_reg.start_val, end_val: slot_reg.end_val,
                                 dur: slot_reg.dur, elapsed: el_hold,
                                 ease: slot_reg.ease};
        end
        rd_data <= slot_mem[i_reg];
    end

    // new elapsed, captured while the loaded word is still on the read port
    always_ff @(posedge aclk) begin
        if (state_reg == ST_TLD) begin
            el_hold <= (el_sum > (DUR_W + 1)'(rd_data.dur)) ? rd_data.dur
                                                            : el_sum[DUR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            dt_reg <= s_time_step;
        end
        if (state_reg == ST_TDIV && div_st.done) begin
            p_reg    <= div_q;
            fin_reg  <= div_q >= eis_pkg::Q_ONE;
            step_reg <= 2'd0;
        end
        if (state_reg == ST_EMUL || state_reg == ST_LMUL) begin
            prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end
        if (state_reg == ST_ERES) begin
            if (slot_reg.ease == eis_pkg::EASE_SMOOTHER && step_reg == 2'd2) begin
                a_reg <= rnd[FRAC_W +: OP_W];
            end else begin
                t_reg <= rnd[FRAC_W +: OP_W];
            end
            step_reg <= step_reg + 2'd1;
        end
        if (state_reg == ST_EFIN) begin
            e_reg <= (e_raw > (OP_W + 1)'(ONE)) ? eis_pkg::Q_ONE : Q_W'(e_raw);
        end
        if (state_reg == ST_LRES) begin
            val_reg <= v_full[VAL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            kind_reg     <= out_kind;
            handle_reg   <= out_handle;
            value_reg    <= out_value;
            finished_reg <= out_fin;
            found_reg    <= out_found;
            last_reg     <= out_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_kind        = kind_reg;
    assign m_slot_handle = handle_reg;
    assign m_value       = $signed(value_reg);
    assign m_finished    = finished_reg;
    assign m_found       = found_reg;
    assign m_last        = last_reg;

`include "eased_interpolation_slot_engine_macros.svh"

    `EIS_ASSERT_IMP(a_div_done_in_div, div_st.done, state_reg == ST_TDIV, "divider done outside divide state")
    `EIS_ASSERT_IMP(a_fin_is_tick, m_valid && m_finished, m_kind == eis_pkg::CMD_TICK && m_found, "finished flag on a non-tick result")
    `EIS_ASSERT_IMP(a_partial_is_tick, m_valid && !m_last, m_kind == eis_pkg::CMD_TICK && m_found, "non-final result outside a tick")
    `EIS_ASSERT_NEXT(a_reset_idle, !aresetn, !m_valid && state_reg == ST_IDLE, "reset left engine busy")

endmodule
